// ===== design/playfair_6x6_cipher_assert.svh =====
// Assertion macros used by the cipher's checker file.
`ifndef PLAYFAIR_6X6_CIPHER_ASSERT_SVH
`define PLAYFAIR_6X6_CIPHER_ASSERT_SVH

// Check a same-cycle implication outside reset.
`define PF6_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication outside reset.
`define PF6_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check a next-cycle implication that also covers reset cycles.
`define PF6_AST_RAW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pf6_pkg.sv =====
// Shared types, constants and helper functions for the 6x6 Playfair cipher.
package pf6_pkg;

  localparam int GRID_SIDE   = 6;
  localparam int NSYM        = GRID_SIDE * GRID_SIDE;
  localparam int SYM_W       = 6;
  localparam int COL_W       = 3;
  localparam int OP_Q_DEPTH  = 4;
  localparam int RES_Q_DEPTH = 4;

  localparam logic [SYM_W-1:0] FILLER_SYM = 6'd23;
  localparam logic [SYM_W-1:0] LAST_SYM   = SYM_W'(NSYM - 1);
  localparam logic [COL_W-1:0] SIDE_LAST  = COL_W'(GRID_SIDE - 1);

  typedef enum logic [2:0] {
    CMD_RESTART = 3'd0,
    CMD_KEY     = 3'd1,
    CMD_FINISH  = 3'd2,
    CMD_TEXT    = 3'd3,
    CMD_END     = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    OP_RESTART,
    OP_KEY,
    OP_FINISH,
    OP_TEXT,
    OP_BAD,
    OP_END
  } op_kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FILL,
    BK_POS,
    BK_GRID,
    BK_SECOND
  } bk_state_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       second_of_pair;
    logic       error;
  } res_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [SYM_W-1:0] sym;
  } op_t;

  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] sym;
  } sym_res_t;

  // Map a byte to a symbol, folding lowercase to uppercase.
  function automatic sym_res_t sym_of_any(input logic [7:0] b);
    sym_res_t r;
    r.ok  = 1'b1;
    r.sym = '0;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r.sym = 6'(b - 8'h41);
    end else if (b >= 8'h61 && b <= 8'h7A) begin
      r.sym = 6'(b - 8'h61);
    end else if (b >= 8'h30 && b <= 8'h39) begin
      r.sym = 6'(b - 8'h30 + 8'd26);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Map a byte to a symbol, accepting uppercase letters and digits only.
  function automatic sym_res_t sym_of_upper(input logic [7:0] b);
    sym_res_t r;
    r.ok  = 1'b1;
    r.sym = '0;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r.sym = 6'(b - 8'h41);
    end else if (b >= 8'h30 && b <= 8'h39) begin
      r.sym = 6'(b - 8'h30 + 8'd26);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [7:0] ascii_of(input logic [SYM_W-1:0] s);
    logic [7:0] w;
    w = {2'b00, s};
    return (s < 6'd26) ? 8'(w + 8'h41) : 8'(w + 8'h30 - 8'd26);
  endfunction

  // Row of a grid position: p/6 as (p*43)>>8, exact for p below 36.
  function automatic logic [COL_W-1:0] row_of(input logic [SYM_W-1:0] p);
    logic [11:0] prod;
    prod = 12'({6'b0, p} * 12'd43);
    return prod[10:8];
  endfunction

  function automatic logic [COL_W-1:0] col_of(input logic [SYM_W-1:0] p,
                                              input logic [COL_W-1:0] r);
    logic [SYM_W-1:0] base;
    base = 6'(({3'b0, r} << 2) + ({3'b0, r} << 1));
    return COL_W'(p - base);
  endfunction

  function automatic logic [SYM_W-1:0] pos_of(input logic [COL_W-1:0] r,
                                              input logic [COL_W-1:0] c);
    return 6'(({3'b0, r} << 2) + ({3'b0, r} << 1) + {3'b0, c});
  endfunction

  // Step one place around a row or column; backward when decrypting.
  function automatic logic [COL_W-1:0] step_of(input logic [COL_W-1:0] c,
                                               input logic back);
    logic [COL_W-1:0] r;
    if (back) begin
      r = (c == '0) ? SIDE_LAST : COL_W'(c - 3'd1);
    end else begin
      r = (c == SIDE_LAST) ? '0 : COL_W'(c + 3'd1);
    end
    return r;
  endfunction

endpackage

// ===== design/pf6_fifo.sv =====
// Small first-word-fall-through queue with a fill level.
module pf6_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               din,
  output logic                       full,
  input  logic                       pop,
  output logic [W-1:0]               dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign level   = cnt_r;
  assign dout    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== design/pf6_front.sv =====
// Front end: accept requests, map bytes to symbols and classify into operations.
module pf6_front (
  input  logic          push,
  input  pf6_pkg::in_t  in_item,
  input  logic          direction,
  input  logic          q_full,
  output logic          full,
  output logic          q_push,
  output pf6_pkg::op_t  q_op
);

  pf6_pkg::sym_res_t any_s;
  pf6_pkg::sym_res_t upper_s;
  logic              keep;

  assign any_s   = pf6_pkg::sym_of_any(in_item.data);
  assign upper_s = pf6_pkg::sym_of_upper(in_item.data);
  assign full    = q_full;

  // Classify the request; drop those that have no effect
  always_comb begin
    keep       = 1'b0;
    q_op.kind  = pf6_pkg::OP_RESTART;
    q_op.sym   = any_s.sym;
    unique case (pf6_pkg::cmd_t'(in_item.cmd))
      pf6_pkg::CMD_RESTART: begin
        keep = 1'b1;
      end
      pf6_pkg::CMD_KEY: begin
        keep      = any_s.ok;
        q_op.kind = pf6_pkg::OP_KEY;
      end
      pf6_pkg::CMD_FINISH: begin
        keep      = 1'b1;
        q_op.kind = pf6_pkg::OP_FINISH;
      end
      pf6_pkg::CMD_TEXT: begin
        if (!direction) begin
          keep      = any_s.ok;
          q_op.kind = pf6_pkg::OP_TEXT;
        end else begin
          keep      = 1'b1;
          q_op.kind = upper_s.ok ? pf6_pkg::OP_TEXT : pf6_pkg::OP_BAD;
          q_op.sym  = upper_s.sym;
        end
      end
      pf6_pkg::CMD_END: begin
        keep      = 1'b1;
        q_op.kind = pf6_pkg::OP_END;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = push && !q_full && keep;

endmodule

// ===== design/pf6_back.sv =====
// Back end: key grid build, digraph pairing, grid lookups and result issue.
module pf6_back #(
  parameter int RES_DEPTH = pf6_pkg::RES_Q_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           direction,
  input  logic                           op_empty,
  input  pf6_pkg::op_t                   op_item,
  output logic                           op_pop,
  input  logic [$clog2(RES_DEPTH+1)-1:0] res_level,
  output logic                           res_push,
  output pf6_pkg::res_t                  res_item
);

  localparam int CW  = $clog2(RES_DEPTH + 1);
  localparam int SW  = pf6_pkg::SYM_W;
  localparam int RW  = pf6_pkg::COL_W;

  pf6_pkg::bk_state_t state_r, state_nxt;

  logic [pf6_pkg::NSYM-1:0] used_r;
  logic [SW-1:0]            fill_r;
  logic [SW-1:0]            held_sym_r;
  logic                     held_vld_r;
  logic [SW-1:0]            sweep_r;
  logic [7:0]               char2_r;

  logic [SW-1:0] grid_mem [pf6_pkg::NSYM];
  logic [SW-1:0] pos_mem  [pf6_pkg::NSYM];
  logic [SW-1:0] pos_a_rd, pos_b_rd;
  logic [SW-1:0] grid_a_rd, grid_b_rd;

  logic          room;
  logic          take;
  logic          pair_go;
  logic          err_go;
  logic          place_req;
  logic          place_en;
  logic [SW-1:0] place_sym;
  logic [SW-1:0] pair_a, pair_b;

  logic [RW-1:0] r1, c1, r2, c2;
  logic [SW-1:0] q1, q2;

  // Take a request only when the result queue can hold a whole pair
  assign room   = (res_level <= CW'(RES_DEPTH - 2));
  assign take   = (state_r == pf6_pkg::BK_IDLE) && !op_empty && room;
  assign op_pop = take;
  assign pair_a = held_sym_r;

  // Decode the request at the head of the queue
  always_comb begin
    pair_go   = 1'b0;
    err_go    = 1'b0;
    place_req = 1'b0;
    place_sym = op_item.sym;
    pair_b    = op_item.sym;
    if (state_r == pf6_pkg::BK_FILL) begin
      place_req = 1'b1;
      place_sym = sweep_r;
    end else if (take) begin
      unique case (op_item.kind)
        pf6_pkg::OP_KEY: begin
          place_req = 1'b1;
        end
        pf6_pkg::OP_TEXT: begin
          pair_go = held_vld_r;
          if (!direction && op_item.sym == held_sym_r) begin
            pair_b = pf6_pkg::FILLER_SYM;
          end
        end
        pf6_pkg::OP_END: begin
          pair_go = held_vld_r && !direction;
          err_go  = held_vld_r && direction;
          pair_b  = pf6_pkg::FILLER_SYM;
        end
        pf6_pkg::OP_BAD: begin
          err_go = 1'b1;
        end
        default: begin
          pair_go = 1'b0;
        end
      endcase
    end
  end

  assign place_en = place_req && (fill_r < SW'(pf6_pkg::NSYM)) && !used_r[place_sym];

  // Apply the row, column or rectangle rule to the looked-up positions
  always_comb begin
    r1 = pf6_pkg::row_of(pos_a_rd);
    r2 = pf6_pkg::row_of(pos_b_rd);
    c1 = pf6_pkg::col_of(pos_a_rd, r1);
    c2 = pf6_pkg::col_of(pos_b_rd, r2);
    if (r1 == r2) begin
      q1 = pf6_pkg::pos_of(r1, pf6_pkg::step_of(c1, direction));
      q2 = pf6_pkg::pos_of(r2, pf6_pkg::step_of(c2, direction));
    end else if (c1 == c2) begin
      q1 = pf6_pkg::pos_of(pf6_pkg::step_of(r1, direction), c1);
      q2 = pf6_pkg::pos_of(pf6_pkg::step_of(r2, direction), c2);
    end else begin
      q1 = pf6_pkg::pos_of(r1, c2);
      q2 = pf6_pkg::pos_of(r2, c1);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pf6_pkg::BK_IDLE: begin
        if (take && op_item.kind == pf6_pkg::OP_FINISH) begin
          state_nxt = pf6_pkg::BK_FILL;
        end else if (pair_go) begin
          state_nxt = pf6_pkg::BK_POS;
        end
      end
      pf6_pkg::BK_FILL: begin
        if (sweep_r == pf6_pkg::LAST_SYM) begin
          state_nxt = pf6_pkg::BK_IDLE;
        end
      end
      pf6_pkg::BK_POS:    state_nxt = pf6_pkg::BK_GRID;
      pf6_pkg::BK_GRID:   state_nxt = pf6_pkg::BK_SECOND;
      pf6_pkg::BK_SECOND: state_nxt = pf6_pkg::BK_IDLE;
      default:            state_nxt = pf6_pkg::BK_IDLE;
    endcase
  end

  // Result issue
  always_comb begin
    res_push                = 1'b0;
    res_item.out_char       = 8'h00;
    res_item.second_of_pair = 1'b0;
    res_item.error          = 1'b0;
    unique case (state_r)
      pf6_pkg::BK_IDLE: begin
        res_push       = err_go;
        res_item.error = 1'b1;
      end
      pf6_pkg::BK_GRID: begin
        res_push          = 1'b1;
        res_item.out_char = pf6_pkg::ascii_of(grid_a_rd);
      end
      pf6_pkg::BK_SECOND: begin
        res_push                = 1'b1;
        res_item.out_char       = char2_r;
        res_item.second_of_pair = 1'b1;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pf6_pkg::BK_IDLE;
      used_r     <= '0;
      fill_r     <= '0;
      held_sym_r <= '0;
      held_vld_r <= 1'b0;
      sweep_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (place_en) begin
        used_r[place_sym] <= 1'b1;
        fill_r            <= SW'(fill_r + 1'b1);
      end
      if (state_r == pf6_pkg::BK_FILL) begin
        sweep_r <= SW'(sweep_r + 1'b1);
      end else begin
        sweep_r <= '0;
      end
      if (take) begin
        unique case (op_item.kind)
          pf6_pkg::OP_RESTART: begin
            used_r     <= '0;
            fill_r     <= '0;
            held_vld_r <= 1'b0;
          end
          pf6_pkg::OP_TEXT: begin
            if (!held_vld_r || pair_b == pf6_pkg::FILLER_SYM && !direction &&
                op_item.sym == held_sym_r) begin
              held_sym_r <= op_item.sym;
              held_vld_r <= 1'b1;
            end else begin
              held_vld_r <= 1'b0;
            end
          end
          pf6_pkg::OP_END: begin
            held_vld_r <= 1'b0;
          end
          default: begin
            held_vld_r <= held_vld_r;
          end
        endcase
      end
    end
  end

  // Hold the second letter of the pair
  always_ff @(posedge clk) begin
    if (state_r == pf6_pkg::BK_GRID) begin
      char2_r <= pf6_pkg::ascii_of(grid_b_rd);
    end
  end

  // Key grid and inverse position map
  always_ff @(posedge clk) begin
    if (place_en) begin
      grid_mem[fill_r]   <= place_sym;
      pos_mem[place_sym] <= fill_r;
    end
    pos_a_rd  <= pos_mem[pair_a];
    pos_b_rd  <= pos_mem[pair_b];
    grid_a_rd <= grid_mem[q1];
    grid_b_rd <= grid_mem[q2];
  end

endmodule

// ===== design/playfair_6x6_cipher.sv =====
// Playfair 6x6 cipher: a text pair steps through the back end's position read,
// grid read and two result writes; key bytes and other requests act when accepted.
// Key finish sweeps all 36 symbols, one per cycle.
// First result of a pair is written from the grid-read state, after the position read.
// Synchronous active-low reset clears queues, key state and direction (encrypt).
// Grid contents stay undefined until a key is loaded.
module playfair_6x6_cipher #(
  parameter int OP_DEPTH  = pf6_pkg::OP_Q_DEPTH,
  parameter int RES_DEPTH = pf6_pkg::RES_Q_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pf6_pkg::in_t  in_item,
  output logic          full,
  output logic          empty,
  input  logic          pop,
  output pf6_pkg::res_t out_item,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  logic                           direction_r;
  logic                           op_push;
  logic                           op_full;
  logic                           op_empty;
  logic                           op_pop;
  pf6_pkg::op_t                   op_in;
  pf6_pkg::op_t                   op_out;
  logic                           res_push;
  pf6_pkg::res_t                  res_in;
  logic [$clog2(RES_DEPTH+1)-1:0] res_level;

  // Direction register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
    end else if (cfg_we) begin
      direction_r <= cfg_wdata;
    end
  end

  pf6_front u_front (
    .push      (push),
    .in_item   (in_item),
    .direction (direction_r),
    .q_full    (op_full),
    .full      (full),
    .q_push    (op_push),
    .q_op      (op_in)
  );

  pf6_fifo #(
    .W     ($bits(pf6_pkg::op_t)),
    .DEPTH (OP_DEPTH)
  ) u_op_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (op_push),
    .din   (op_in),
    .full  (op_full),
    .pop   (op_pop),
    .dout  (op_out),
    .empty (op_empty),
    .level ()
  );

  pf6_back #(
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .direction (direction_r),
    .op_empty  (op_empty),
    .op_item   (op_out),
    .op_pop    (op_pop),
    .res_level (res_level),
    .res_push  (res_push),
    .res_item  (res_in)
  );

  pf6_fifo #(
    .W     ($bits(pf6_pkg::res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (),
    .pop   (pop),
    .dout  (out_item),
    .empty (empty),
    .level (res_level)
  );

endmodule

// ===== design/pf6_checker.sv =====
// Port-level checker for the cipher, bound to the top level.
`include "playfair_6x6_cipher_assert.svh"

module pf6_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          empty,
  input logic          pop,
  input pf6_pkg::res_t out_item
);

  // Error results carry no letter and no pair mark
  `PF6_AST_NOW(a_err_fields, !empty && out_item.error, out_item.out_char == 8'h00 && !out_item.second_of_pair, "error result carries data")

  // Second letter follows the first with no gap
  `PF6_AST_NXT(a_pair_follows, pop && !empty && !out_item.error && !out_item.second_of_pair, !empty && out_item.second_of_pair, "second of pair missing")

  // Hold a stalled result
  `PF6_AST_NXT(a_res_hold, !empty && !pop, !empty && $stable(out_item), "stalled result changed")

  // Drain the result side on reset
  `PF6_AST_RAW(a_rst_empty, !rst_n, empty, "results present after reset")

endmodule

bind playfair_6x6_cipher pf6_checker u_pf6_checker (.*);
